// ===== rtl/tobs_pkg.sv =====
// ----------------------------------------------------------------------------
// tobs_pkg
// types and constants shared by the tagged operand byte serializer
// ----------------------------------------------------------------------------
`default_nettype none

package tobs_pkg;

    // operand request kinds
    typedef enum logic [3:0] {
        KIND_CMD      = 4'd0,
        KIND_END      = 4'd1,
        KIND_INT_AUTO = 4'd2,
        KIND_I8       = 4'd3,
        KIND_I16      = 4'd4,
        KIND_I32      = 4'd5,
        KIND_FLOAT    = 4'd6,
        KIND_GVAR     = 4'd7,
        KIND_LVAR     = 4'd8,
        KIND_RAW8     = 4'd9,
        KIND_RAW16    = 4'd10,
        KIND_RAW32    = 4'd11
    } kind_t;

    // type tags
    localparam logic [7:0] TAG_EOAL  = 8'd0;
    localparam logic [7:0] TAG_I32   = 8'd1;
    localparam logic [7:0] TAG_GVAR  = 8'd2;
    localparam logic [7:0] TAG_LVAR  = 8'd3;
    localparam logic [7:0] TAG_I8    = 8'd4;
    localparam logic [7:0] TAG_I16   = 8'd5;
    localparam logic [7:0] TAG_FLOAT = 8'd6;

    localparam int unsigned MAX_BYTES = 5;
    localparam int unsigned CNT_W     = 3;

    // q11.4 saturation codes
    localparam logic [15:0] FIX_MIN = 16'h8000;
    localparam logic [15:0] FIX_MAX = 16'h7FFF;
    localparam logic [15:0] CMD_NEG = 16'h8000;

    // binary32 exponent limits
    localparam logic [7:0] EXP_ALL_ONES = 8'hFF;
    localparam logic [7:0] EXP_SAT      = 8'd138;
    localparam logic [7:0] EXP_BIAS_SH  = 8'd146;

    // one encoded operand: bytes in send order, lowest byte first
    typedef struct packed {
        logic [MAX_BYTES*8-1:0] bytes;
        logic [CNT_W-1:0]       count;
    } enc_t;

endpackage

`default_nettype wire

// ===== rtl/tobs_encoder.sv =====
// ----------------------------------------------------------------------------
// tobs_encoder
// turns one operand request into its tagged little-endian byte string
// ----------------------------------------------------------------------------
`default_nettype none

module tobs_encoder (
    input  wire logic [3:0]         kind,
    input  wire logic signed [31:0] int_value,
    input  wire logic [15:0]        word,
    input  wire logic               negate,
    input  wire logic [31:0]        float_bits,
    output tobs_pkg::enc_t          enc
);

    logic [31:0] ival;
    logic        fits_i8;
    logic        fits_i16;
    logic [15:0] cmd_word;

    // float to q11.4
    logic        f_sign;
    logic [7:0]  f_exp;
    logic [22:0] f_man;
    logic [23:0] f_sig;
    logic [7:0]  f_shift;
    logic [23:0] f_mag;
    logic [15:0] f_fix;

    assign ival     = int_value;
    assign fits_i8  = (&ival[31:7]) | ~(|ival[31:7]);
    assign fits_i16 = (&ival[31:15]) | ~(|ival[31:15]);
    assign cmd_word = {1'b0, word[14:0]} | (negate ? tobs_pkg::CMD_NEG : 16'h0000);

    assign f_sign  = float_bits[31];
    assign f_exp   = float_bits[30:23];
    assign f_man   = float_bits[22:0];
    assign f_sig   = (f_exp == 8'd0) ? {1'b0, f_man} : {1'b1, f_man};
    // subnormals use an effective exponent of one
    assign f_shift = tobs_pkg::EXP_BIAS_SH - ((f_exp == 8'd0) ? 8'd1 : f_exp);
    assign f_mag   = (f_shift >= 8'd24) ? 24'd0 : (f_sig >> f_shift[4:0]);

    always_comb begin
        if (f_exp == tobs_pkg::EXP_ALL_ONES && f_man != 23'd0) begin
            f_fix = tobs_pkg::FIX_MIN;
        end else if (f_exp >= tobs_pkg::EXP_SAT) begin
            f_fix = f_sign ? tobs_pkg::FIX_MIN : tobs_pkg::FIX_MAX;
        end else if (f_sign) begin
            f_fix = 16'd0 - f_mag[15:0];
        end else begin
            f_fix = f_mag[15:0];
        end
    end

    always_comb begin
        enc.bytes = '0;
        enc.count = '0;
        unique case (kind)
            tobs_pkg::KIND_CMD: begin
                enc.bytes[15:0] = cmd_word;
                enc.count       = 3'd2;
            end
            tobs_pkg::KIND_END: begin
                enc.bytes[7:0] = tobs_pkg::TAG_EOAL;
                enc.count      = 3'd1;
            end
            tobs_pkg::KIND_INT_AUTO: begin
                if (fits_i8) begin
                    enc.bytes[15:0] = {ival[7:0], tobs_pkg::TAG_I8};
                    enc.count       = 3'd2;
                end else if (fits_i16) begin
                    enc.bytes[23:0] = {ival[15:0], tobs_pkg::TAG_I16};
                    enc.count       = 3'd3;
                end else begin
                    enc.bytes = {ival, tobs_pkg::TAG_I32};
                    enc.count = 3'd5;
                end
            end
            tobs_pkg::KIND_I8: begin
                enc.bytes[15:0] = {ival[7:0], tobs_pkg::TAG_I8};
                enc.count       = 3'd2;
            end
            tobs_pkg::KIND_I16: begin
                enc.bytes[23:0] = {ival[15:0], tobs_pkg::TAG_I16};
                enc.count       = 3'd3;
            end
            tobs_pkg::KIND_I32: begin
                enc.bytes = {ival, tobs_pkg::TAG_I32};
                enc.count = 3'd5;
            end
            tobs_pkg::KIND_FLOAT: begin
                enc.bytes[23:0] = {f_fix, tobs_pkg::TAG_FLOAT};
                enc.count       = 3'd3;
            end
            tobs_pkg::KIND_GVAR: begin
                enc.bytes[23:0] = {word, tobs_pkg::TAG_GVAR};
                enc.count       = 3'd3;
            end
            tobs_pkg::KIND_LVAR: begin
                enc.bytes[23:0] = {word, tobs_pkg::TAG_LVAR};
                enc.count       = 3'd3;
            end
            tobs_pkg::KIND_RAW8: begin
                enc.bytes[7:0] = ival[7:0];
                enc.count      = 3'd1;
            end
            tobs_pkg::KIND_RAW16: begin
                enc.bytes[15:0] = word;
                enc.count       = 3'd2;
            end
            tobs_pkg::KIND_RAW32: begin
                enc.bytes[31:0] = ival;
                enc.count       = 3'd4;
            end
            default: begin
                // unused kinds emit nothing
                enc.bytes = '0;
                enc.count = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/tagged_operand_byte_serializer_top.sv =====
// ----------------------------------------------------------------------------
// tagged_operand_byte_serializer_top
// operand request in, tagged little-endian bytecode bytes out
// ----------------------------------------------------------------------------
// usage:
//   - slave channel: one operand request per transfer; s_tuser carries the
//     kind, s_tdata the operand fields
//   - master channel: one bytecode byte per transfer with its stream offset;
//     m_tlast marks the final byte caused by a request
//   - a request is captured in an input register, encoded by short logic and
//     loaded into a byte shift register that drives the master outputs
//   - path: a request passes through the input register and the encoder into
//     the byte shift register once it is free, which then presents its first byte
//   - throughput: one byte per cycle while m_tready is high; a request of n
//     bytes (1 to 5) occupies the output for n byte transfers; the next request
//     is loaded while the last byte of the current one leaves
//   - requests of an unused kind produce no bytes
//   - stalls: while m_tready is low the byte and offset hold; once the input
//     register is full s_tready drops until the encoded string is loaded
//   - reset: aresetn low clears both stages and the stream offset to zero
// ----------------------------------------------------------------------------
`default_nettype none

module tagged_operand_byte_serializer_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // slave request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [87:0] s_tdata,   // int_value[31:0], word[47:32], negate[48],
                                        // float_bits[80:49], zero[87:81]
    input  wire logic [3:0]  s_tuser,   // kind[3:0]
    // master byte channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // out_byte[7:0], byte_offset[39:8]
    output logic             m_tlast    // last byte of the request
);

    // input register
    logic        item_valid_reg;
    logic [3:0]  kind_reg;
    logic [31:0] int_value_reg;
    logic [15:0] word_reg;
    logic        negate_reg;
    logic [31:0] float_bits_reg;

    // byte shift register and stream offset
    logic [tobs_pkg::MAX_BYTES*8-1:0] bytes_reg;
    logic [tobs_pkg::CNT_W-1:0]       remain_reg;
    logic [31:0]                      offset_reg;

    tobs_pkg::enc_t enc;
    logic           out_xfer;
    logic           load;

    tobs_encoder u_encoder (
        .kind       (kind_reg),
        .int_value  (int_value_reg),
        .word       (word_reg),
        .negate     (negate_reg),
        .float_bits (float_bits_reg),
        .enc        (enc)
    );

    assign out_xfer = m_tvalid && m_tready;
    // load the encoded string when the shifter is empty or its last byte leaves
    assign load     = item_valid_reg &&
                      ((remain_reg == '0) || (remain_reg == 3'd1 && m_tready));
    assign s_tready = !item_valid_reg || load;

    // capture requests
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_tready) begin
            item_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            kind_reg       <= s_tuser;
            int_value_reg  <= s_tdata[31:0];
            word_reg       <= s_tdata[47:32];
            negate_reg     <= s_tdata[48];
            float_bits_reg <= s_tdata[80:49];
        end
    end

    // byte shifter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remain_reg <= '0;
        end else if (load) begin
            remain_reg <= enc.count;
        end else if (out_xfer) begin
            remain_reg <= remain_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            bytes_reg <= enc.bytes;
        end else if (out_xfer) begin
            bytes_reg <= bytes_reg >> 8;
        end
    end

    // stream offset advances once per byte transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
        end else if (out_xfer) begin
            offset_reg <= offset_reg + 32'd1;
        end
    end

    assign m_tvalid = (remain_reg != '0);
    assign m_tdata  = {offset_reg, bytes_reg[7:0]};
    assign m_tlast  = (remain_reg == 3'd1);

endmodule

`default_nettype wire

// ===== sim/tobs_byte_checker.sv =====
// ----------------------------------------------------------------------------
// tobs_byte_checker
// watches both channels of the operand serializer, predicts every bytecode
// byte with its stream offset and last flag, and compares in order
// ----------------------------------------------------------------------------
`default_nettype none

module tobs_byte_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [87:0] s_tdata,
    input  wire logic [3:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata,
    input  wire logic        m_tlast,
    output int               fail_count,
    output int               pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]  data;
        logic [31:0] offset;
        logic        last;
    } stream_byte_t;

    stream_byte_t expected_bytes_q[$];
    logic [31:0]  next_offset;

    // binary32 to q11.4, truncating toward zero, saturating
    function automatic logic [15:0] q11_4_of(input logic [31:0] fbits);
        logic        sgn;
        logic [7:0]  ex;
        logic [22:0] man;
        logic [23:0] sig;
        int          shift;
        logic [15:0] mag;
        sgn = fbits[31];
        ex  = fbits[30:23];
        man = fbits[22:0];
        if (ex == tobs_pkg::EXP_ALL_ONES && man != 23'd0) begin
            return tobs_pkg::FIX_MIN;
        end
        if (ex >= tobs_pkg::EXP_SAT) begin
            return sgn ? tobs_pkg::FIX_MIN : tobs_pkg::FIX_MAX;
        end
        if (ex == 8'd0) begin
            sig   = {1'b0, man};
            shift = int'(tobs_pkg::EXP_BIAS_SH) - 1;
        end else begin
            sig   = {1'b1, man};
            shift = int'(tobs_pkg::EXP_BIAS_SH) - int'(ex);
        end
        mag = (shift >= 24) ? 16'd0 : 16'(sig >> shift);
        return sgn ? 16'(16'd0 - mag) : mag;
    endfunction

    // bytes of one operand request, lowest byte first
    function automatic tobs_pkg::enc_t encode_operand(input logic [3:0] kind,
                                                      input logic [31:0] ival,
                                                      input logic [15:0] word,
                                                      input logic neg,
                                                      input logic [31:0] fbits);
        tobs_pkg::enc_t enc;
        logic [31:0]    off8;
        logic [31:0]    off16;
        enc.bytes = '0;
        enc.count = '0;
        off8  = ival + 32'h80;
        off16 = ival + 32'h8000;
        case (kind)
            tobs_pkg::KIND_CMD: begin
                enc.bytes[15:0] = {neg, word[14:0]};
                enc.count       = 3'd2;
            end
            tobs_pkg::KIND_END: begin
                enc.bytes[7:0] = tobs_pkg::TAG_EOAL;
                enc.count      = 3'd1;
            end
            tobs_pkg::KIND_INT_AUTO: begin
                if (off8 < 32'h100) begin
                    enc.bytes[15:0] = {ival[7:0], tobs_pkg::TAG_I8};
                    enc.count       = 3'd2;
                end else if (off16 < 32'h10000) begin
                    enc.bytes[23:0] = {ival[15:0], tobs_pkg::TAG_I16};
                    enc.count       = 3'd3;
                end else begin
                    enc.bytes = {ival, tobs_pkg::TAG_I32};
                    enc.count = 3'd5;
                end
            end
            tobs_pkg::KIND_I8: begin
                enc.bytes[15:0] = {ival[7:0], tobs_pkg::TAG_I8};
                enc.count       = 3'd2;
            end
            tobs_pkg::KIND_I16: begin
                enc.bytes[23:0] = {ival[15:0], tobs_pkg::TAG_I16};
                enc.count       = 3'd3;
            end
            tobs_pkg::KIND_I32: begin
                enc.bytes = {ival, tobs_pkg::TAG_I32};
                enc.count = 3'd5;
            end
            tobs_pkg::KIND_FLOAT: begin
                enc.bytes[23:0] = {q11_4_of(fbits), tobs_pkg::TAG_FLOAT};
                enc.count       = 3'd3;
            end
            tobs_pkg::KIND_GVAR: begin
                enc.bytes[23:0] = {word, tobs_pkg::TAG_GVAR};
                enc.count       = 3'd3;
            end
            tobs_pkg::KIND_LVAR: begin
                enc.bytes[23:0] = {word, tobs_pkg::TAG_LVAR};
                enc.count       = 3'd3;
            end
            tobs_pkg::KIND_RAW8: begin
                enc.bytes[7:0] = ival[7:0];
                enc.count      = 3'd1;
            end
            tobs_pkg::KIND_RAW16: begin
                enc.bytes[15:0] = word;
                enc.count       = 3'd2;
            end
            tobs_pkg::KIND_RAW32: begin
                enc.bytes[31:0] = ival;
                enc.count       = 3'd4;
            end
            default: begin
                enc.count = 3'd0;
            end
        endcase
        return enc;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin : monitor
        tobs_pkg::enc_t enc;
        stream_byte_t   want;
        stream_byte_t   nb;
        if (!aresetn) begin
            next_offset = 32'd0;
            expected_bytes_q.delete();
        end else begin
            // requests first, so a byte never overtakes its own prediction
            if (s_tvalid && s_tready) begin
                enc = encode_operand(s_tuser, s_tdata[31:0], s_tdata[47:32], s_tdata[48],
                                     s_tdata[80:49]);
                for (int k = 0; k < int'(enc.count); k++) begin
                    nb.data   = enc.bytes[k*8 +: 8];
                    nb.offset = next_offset;
                    nb.last   = (k == int'(enc.count) - 1);
                    expected_bytes_q.insert(expected_bytes_q.size(), nb);
                    next_offset = next_offset + 32'd1;
                end
            end
            if (m_tvalid && m_tready) begin
                if (expected_bytes_q.size() == 0) begin
                    report_mismatch("byte with nothing pending", {24'd0, m_tdata[7:0]}, 32'd0);
                end else begin
                    want = expected_bytes_q.pop_front();
                    if (m_tdata[7:0] != want.data)
                        report_mismatch("byte value", {24'd0, m_tdata[7:0]}, {24'd0, want.data});
                    if (m_tdata[39:8] != want.offset)
                        report_mismatch("byte offset", m_tdata[39:8], want.offset);
                    if (m_tlast != want.last)
                        report_mismatch("last flag", {31'd0, m_tlast}, {31'd0, want.last});
                end
            end
        end
        pending_count <= expected_bytes_q.size();
    end

endmodule

`default_nettype wire

// ===== sim/tb_tagged_operand_byte_serializer_top.sv =====
// ----------------------------------------------------------------------------
// tb_tagged_operand_byte_serializer_top
// drives operand requests into the serializer and gives the verdict; a
// directed pass over edge values and every kind is followed by random
// requests under random gaps, back-pressure and one long output stall
// ----------------------------------------------------------------------------
`default_nettype none

module tb_tagged_operand_byte_serializer_top;
    timeunit 1ns;
    timeprecision 1ps;

    // kind code with no encoding, the block drops it
    localparam logic [3:0] KIND_SPARE   = 4'd15;
    localparam int         RANDOM_OPS   = 280;
    localparam int         LONG_HOLD    = 300;
    localparam int         HOLD_AT_BYTE = 80;
    localparam int         DRAIN_CYCLES = 12;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata  = '0;
    logic [3:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    int fail_count;
    int pending_count;

    // when set, that side runs without gaps
    logic src_steady  = 1'b0;
    logic sink_steady = 1'b0;

    always #5 aclk = ~aclk;

    tagged_operand_byte_serializer_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // int_value[31:0], word[47:32], negate[48], float_bits[80:49]
        .s_tuser  (s_tuser),    // kind[3:0]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // out_byte[7:0], byte_offset[39:8]
        .m_tlast  (m_tlast)
    );

    tobs_byte_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // one request transfer; tvalid stays high into the next request when
    // no gap is drawn, so it is never dropped and raised in the same step
    task automatic send_op(input logic [3:0] kind, input logic [31:0] ival,
                           input logic [15:0] word, input logic neg,
                           input logic [31:0] fbits);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, fbits, neg, word, ival};
        do @(posedge aclk); while (!s_tready);
    endtask

    // integer operand, weighted toward the size boundaries
    function automatic logic [31:0] pick_int();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 4))
            0: return {{24{r[7]}}, r[7:0]};
            1: return {{16{r[15]}}, r[15:0]};
            2: begin
                case ($urandom_range(0, 7))
                    0: return 32'd127;
                    1: return 32'd128;
                    2: return -32'sd128;
                    3: return -32'sd129;
                    4: return 32'd32767;
                    5: return 32'd32768;
                    6: return -32'sd32768;
                    default: return -32'sd32769;
                endcase
            end
            default: return r;
        endcase
    endfunction

    // float pattern: in range, near saturation, specials, subnormals, anything
    function automatic logic [31:0] pick_float();
        logic [31:0] r;
        logic [7:0]  ex;
        logic [22:0] man;
        r   = $urandom;
        man = $urandom_range(0, 1) ? r[22:0] : 23'd0;
        case ($urandom_range(0, 4))
            0: begin
                ex = 8'($urandom_range(100, 140));
                return {r[31], ex, r[22:0]};
            end
            1: begin
                ex = 8'($urandom_range(136, 138));
                return {r[31], ex, r[22:0]};
            end
            2: return {r[31], tobs_pkg::EXP_ALL_ONES, man};
            3: return {r[31], 8'd0, man};
            default: return $urandom;
        endcase
    endfunction

    // receiver: random stalls per byte, plus one long hold so the block fills
    initial begin : sink
        int  stall;
        int  bytes_taken;
        bit  held;
        bytes_taken = 0;
        held        = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (!held && bytes_taken >= HOLD_AT_BYTE) begin
                stall = LONG_HOLD;
                held  = 1'b1;
            end else begin
                stall = sink_steady ? 0 : $urandom_range(0, 10);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            bytes_taken++;
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        logic [3:0] kind;
        int         sent;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: command word with bit 15 of the id ignored, negate set
        send_op(tobs_pkg::KIND_CMD, 32'd0, 16'hFFFF, 1'b0, 32'd0);
        send_op(tobs_pkg::KIND_CMD, 32'hFFFF_FFFF, 16'h0000, 1'b1, 32'hFFFF_FFFF);
        send_op(tobs_pkg::KIND_END, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
        // automatic sizing: both sides of the i8 bounds, the top of the i16 range, just below its bottom, i32 extremes
        send_op(tobs_pkg::KIND_INT_AUTO, 32'd127, 16'd0, 1'b0, 32'd0);
        send_op(tobs_pkg::KIND_INT_AUTO, 32'd128, 16'd0, 1'b0, 32'd0);
        send_op(tobs_pkg::KIND_INT_AUTO, -32'sd128, 16'd0, 1'b0, 32'd0);
        send_op(tobs_pkg::KIND_INT_AUTO, -32'sd129, 16'd0, 1'b0, 32'd0);
        send_op(tobs_pkg::KIND_INT_AUTO, 32'd32767, 16'd0, 1'b0, 32'd0);
        send_op(tobs_pkg::KIND_INT_AUTO, -32'sd32769, 16'd0, 1'b0, 32'd0);
        send_op(tobs_pkg::KIND_INT_AUTO, 32'h7FFF_FFFF, 16'd0, 1'b0, 32'd0);
        send_op(tobs_pkg::KIND_INT_AUTO, 32'h8000_0000, 16'd0, 1'b0, 32'd0);
        // forced sizes wrap without a range check
        send_op(tobs_pkg::KIND_I8, 32'h0001_2345, 16'd0, 1'b0, 32'd0);
        send_op(tobs_pkg::KIND_I16, 32'h000A_BCDE, 16'd0, 1'b0, 32'd0);
        send_op(tobs_pkg::KIND_I32, 32'hFFFF_FFFF, 16'd0, 1'b0, 32'd0);
        // floats: nan, both infinities, top of range, negative fraction, subnormal
        send_op(tobs_pkg::KIND_FLOAT, 32'd0, 16'd0, 1'b0, 32'h7FC0_0000);
        send_op(tobs_pkg::KIND_FLOAT, 32'd0, 16'd0, 1'b0, 32'h7F80_0000);
        send_op(tobs_pkg::KIND_FLOAT, 32'd0, 16'd0, 1'b0, 32'hFF80_0000);
        send_op(tobs_pkg::KIND_FLOAT, 32'd0, 16'd0, 1'b0, 32'h44FF_FE00);
        send_op(tobs_pkg::KIND_FLOAT, 32'd0, 16'd0, 1'b0, 32'hBFC0_0000);
        send_op(tobs_pkg::KIND_FLOAT, 32'd0, 16'd0, 1'b0, 32'h0000_0001);
        send_op(tobs_pkg::KIND_GVAR, 32'd0, 16'hFFFF, 1'b0, 32'd0);
        send_op(tobs_pkg::KIND_LVAR, 32'd0, 16'h0000, 1'b0, 32'd0);
        send_op(tobs_pkg::KIND_RAW8, 32'hFFFF_FF80, 16'd0, 1'b0, 32'd0);
        send_op(tobs_pkg::KIND_RAW16, 32'd0, 16'hA55A, 1'b0, 32'd0);
        send_op(tobs_pkg::KIND_RAW32, 32'hDEAD_BEEF, 16'd0, 1'b0, 32'd0);
        // unused kind produces nothing and leaves the offset alone
        send_op(KIND_SPARE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);

        // random requests; every 40 the idling pattern of each side changes
        sent = 0;
        while (sent < RANDOM_OPS) begin
            if (sent % 40 == 0) begin
                src_steady  = ($urandom_range(0, 3) == 0);
                sink_steady = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 19) == 0) begin
                kind = 4'($urandom_range(int'(tobs_pkg::KIND_RAW32) + 1, 15));
            end else begin
                kind = 4'($urandom_range(int'(tobs_pkg::KIND_CMD),
                                         int'(tobs_pkg::KIND_RAW32)));
                sent++;
            end
            send_op(kind, pick_int(), 16'($urandom), 1'($urandom), pick_float());
        end
        s_tvalid <= 1'b0;
        src_steady  = 1'b0;
        sink_steady = 1'b0;

        // let the last prediction land, then drain
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin : watchdog
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
